// ===== hw/rtl/tsh_pkg.sv =====
// ----------------------------------------------------------------------------
// tsh_pkg
// Shared constants and tables for the triangle shape histogram.
// ----------------------------------------------------------------------------
package tsh_pkg;

  localparam int SCALE_BINS = 50;
  localparam int RATIO_BINS = 16;
  localparam int ANGLE_BINS = 32;
  localparam int HIST_DEPTH = SCALE_BINS * RATIO_BINS * ANGLE_BINS;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  localparam int COORD_W = 24;
  localparam int SQ_W    = 50;
  localparam int LEN_W   = 25;
  localparam int NUM_W   = 52;
  localparam int DEN_W   = 51;
  localparam int COS_W   = 31;
  localparam int XY_W    = 34;
  localparam int Z_W     = 23;
  localparam int ANG_W   = 21;
  localparam int RAT_W   = 37;
  localparam int SCL_W   = 25;
  localparam int RTR_W   = 20;
  localparam int BIN_W   = 8;
  localparam int CNT_W   = 32;
  localparam int CFG_IW  = 3;

  localparam int DIV_NW  = 62;
  localparam int DIV_DW  = 32;
  localparam int SQRT_IW = 64;
  localparam int SQRT_OW = 32;

  localparam int CORDIC_STEPS = 18;
  localparam int ANG_ONE      = 1048576;
  localparam int ANG_HALF     = 524288;
  localparam int COS_ONE      = 1073741824;

  localparam logic [CFG_IW-1:0] CFG_SCALE_LOW  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_SCALE_HIGH = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_RATIO_LOW  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_RATIO_HIGH = 3'd3;

  localparam logic CMD_ACC  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // atan(2^-i) / pi in Q.20
  function automatic logic [18:0] atan_tab(input logic [4:0] i);
    logic [18:0] v;
    case (i)
      5'd0:    v = 19'd262144;
      5'd1:    v = 19'd154753;
      5'd2:    v = 19'd81767;
      5'd3:    v = 19'd41506;
      5'd4:    v = 19'd20834;
      5'd5:    v = 19'd10427;
      5'd6:    v = 19'd5215;
      5'd7:    v = 19'd2608;
      5'd8:    v = 19'd1304;
      5'd9:    v = 19'd652;
      5'd10:   v = 19'd326;
      5'd11:   v = 19'd163;
      5'd12:   v = 19'd81;
      5'd13:   v = 19'd41;
      5'd14:   v = 19'd20;
      5'd15:   v = 19'd10;
      5'd16:   v = 19'd5;
      5'd17:   v = 19'd3;
      default: v = 19'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/triangle_shape_histogram_top.sv =====
// ----------------------------------------------------------------------------
// triangle_shape_histogram_top
// Bins triangle shapes (scale, side ratio, angle) into a counter memory.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// for one cycle with done high and cannot be held off. After reset busy stays
// high while the counter memory is cleared one entry a cycle. A read request
// goes through S_RD, where the registered memory output is put on the ports
// with done; the next request can be taken once the block is back in S_IDLE.
// An accumulate request ends early for a degenerate triangle; otherwise its
// length is set by the shared bit-serial divider (up to eleven uses), the
// square root unit (five uses), the 18-step angle iteration and one
// read-modify-write per counted bin.
module triangle_shape_histogram_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cmd,
  input  logic signed [23:0]          ax,
  input  logic signed [23:0]          ay,
  input  logic signed [23:0]          az,
  input  logic signed [23:0]          bx,
  input  logic signed [23:0]          by_coord,
  input  logic signed [23:0]          bz,
  input  logic signed [23:0]          cx,
  input  logic signed [23:0]          cy,
  input  logic signed [23:0]          cz,
  input  logic [14:0]                 read_bin,
  input  logic                        wr_en,
  input  logic [tsh_pkg::CFG_IW-1:0]  wr_index,
  input  logic [24:0]                 wr_data,
  output logic                        done,
  output logic [31:0]                 bin_count,
  output logic [1:0]                  bins_added
);
  import tsh_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD, S_SQ_M, S_SQ_A, S_SORT, S_LEN_GO, S_LEN_W,
    S_V_NUM, S_V_DEN, S_V_CMP, S_V_SH, S_V_DIV, S_V_SIN, S_V_SQ, S_V_SQW,
    S_V_COR, S_V_END, S_O_ANG, S_O_RATW, S_O_RBW, S_O_SBW, S_O_RD, S_O_WR,
    S_O_NEXT, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [SCL_W-1:0] scale_low, scale_high;
  logic [RTR_W-1:0] ratio_low, ratio_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_low  <= SCL_W'(512);
      scale_high <= SCL_W'(3072);
      ratio_low  <= RTR_W'(3686);
      ratio_high <= RTR_W'(16794);
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_SCALE_LOW:  scale_low  <= wr_data[SCL_W-1:0];
        CFG_SCALE_HIGH: scale_high <= wr_data[SCL_W-1:0];
        CFG_RATIO_LOW:  ratio_low  <= wr_data[RTR_W-1:0];
        CFG_RATIO_HIGH: ratio_high <= wr_data[RTR_W-1:0];
        default: ;
      endcase
    end
  end

  // counter memory
  logic [CNT_W-1:0]   mem [HIST_DEPTH];
  logic [CNT_W-1:0]   mem_q;
  logic               mem_we;
  logic [HIST_AW-1:0] mem_waddr, mem_raddr;
  logic [CNT_W-1:0]   mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q <= mem[mem_raddr];
  end

  // working registers
  logic [HIST_AW-1:0] clr_addr, flat;
  logic               rd_ok;
  logic signed [COORD_W-1:0] pax, pay, paz, pbx, pby, pbz, pcx, pcy, pcz;
  logic [1:0]         side_i, axis_i, sort_i, len_i, oidx;
  logic               vidx;
  logic [4:0]         ci;
  logic [SQ_W-1:0]    sq0, sq1, sq2, acc, acc_next;
  logic [LEN_W-1:0]   len0, len1, len2;
  logic signed [NUM_W-1:0] num;
  logic [DEN_W-1:0]   den, mag;
  logic [COS_W-1:0]   cm;
  logic signed [XY_W-1:0] cx_r, cy_r;
  logic signed [Z_W-1:0]  cz_r;
  logic [ANG_W-1:0]   ang0, ang1;
  logic [BIN_W-1:0]   ab, rb;
  logic [1:0]         added;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  always_ff @(posedge clk) mul_p <= mul_a * mul_b;

  // shared divider and square root
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_dvd, div_q;
  logic [DIV_DW-1:0] div_dvs;
  logic               sqrt_start, sqrt_done;
  logic [SQRT_IW-1:0] sqrt_rad;
  logic [SQRT_OW-1:0] sqrt_root;

  tsh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  tsh_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  function automatic logic signed [XY_W-1:0] shr_tz(input logic signed [XY_W-1:0] v,
                                                    input logic [4:0] sh);
    logic signed [XY_W-1:0] m;
    m = -v;
    if (v < 0) return -(m >>> sh);
    return v >>> sh;
  endfunction

  // coordinate difference for the squared lengths
  logic signed [COORD_W:0] diff;

  always_comb begin
    case ({side_i, axis_i})
      4'h0:    diff = {pax[COORD_W-1], pax} - {pbx[COORD_W-1], pbx};
      4'h1:    diff = {pay[COORD_W-1], pay} - {pby[COORD_W-1], pby};
      4'h2:    diff = {paz[COORD_W-1], paz} - {pbz[COORD_W-1], pbz};
      4'h4:    diff = {pax[COORD_W-1], pax} - {pcx[COORD_W-1], pcx};
      4'h5:    diff = {pay[COORD_W-1], pay} - {pcy[COORD_W-1], pcy};
      4'h6:    diff = {paz[COORD_W-1], paz} - {pcz[COORD_W-1], pcz};
      4'h8:    diff = {pbx[COORD_W-1], pbx} - {pcx[COORD_W-1], pcx};
      4'h9:    diff = {pby[COORD_W-1], pby} - {pcy[COORD_W-1], pcy};
      4'hA:    diff = {pbz[COORD_W-1], pbz} - {pcz[COORD_W-1], pcz};
      default: diff = '0;
    endcase
  end

  assign acc_next = (axis_i == 2'd0 ? SQ_W'(0) : acc) + mul_p[SQ_W-1:0];

  // per-vertex operands
  logic [SQ_W-1:0]  p2, r2, o2, sq_sel;
  logic [LEN_W-1:0] lp, lr;

  always_comb begin
    if (vidx) begin
      p2 = sq1; r2 = sq2; o2 = sq0; lp = len1; lr = len2;
    end else begin
      p2 = sq0; r2 = sq1; o2 = sq2; lp = len0; lr = len1;
    end
    case (len_i)
      2'd0:    sq_sel = sq0;
      2'd1:    sq_sel = sq1;
      default: sq_sel = sq2;
    endcase
  end

  logic signed [NUM_W-1:0] num_calc;
  assign num_calc = $signed({2'b00, p2}) + $signed({2'b00, r2}) - $signed({2'b00, o2});

  // CORDIC step
  logic signed [XY_W-1:0] cdx, cdy;
  logic signed [Z_W-1:0]  ct;
  assign cdx = shr_tz(cx_r, ci);
  assign cdy = shr_tz(cy_r, ci);
  assign ct  = $signed({4'b0000, atan_tab(ci)});

  // per-orientation operands
  logic [LEN_W-1:0]      len_s, len_t, len_b;
  logic signed [Z_W-1:0] ang_k, ang2;
  logic                  ang_ok, scl_ok, rat_ok;
  logic [RAT_W-1:0]      rat_v, rdiff;
  logic [28:0]           ang_scaled;

  assign ang2 = $signed(Z_W'(ANG_ONE)) - $signed({2'b00, ang0}) - $signed({2'b00, ang1});

  always_comb begin
    case (oidx)
      2'd0:    begin len_s = len0; len_t = len1; len_b = len0;
                     ang_k = $signed({2'b00, ang0}); end
      2'd1:    begin len_s = len1; len_t = len2; len_b = len1;
                     ang_k = $signed({2'b00, ang1}); end
      default: begin len_s = len0; len_t = len2; len_b = len0; ang_k = ang2; end
    endcase
  end

  assign ang_ok     = !ang_k[Z_W-1] && (ang_k < $signed(Z_W'(ANG_ONE)));
  assign scl_ok     = (len_s >= scale_low) && (len_s < scale_high);
  assign rat_v      = div_q[RAT_W-1:0];
  assign rat_ok     = (rat_v >= RAT_W'(ratio_low)) && (rat_v < RAT_W'(ratio_high));
  assign rdiff      = rat_v - RAT_W'(ratio_low);
  assign ang_scaled = 29'(ang_k[19:0]) * 29'(ANGLE_BINS);

  // unit requests and memory port
  always_comb begin
    div_start  = 1'b0;
    div_dvd    = '0;
    div_dvs    = '0;
    sqrt_start = 1'b0;
    sqrt_rad   = '0;
    mul_a      = '0;
    mul_b      = '0;
    mem_we     = 1'b0;
    mem_waddr  = flat;
    mem_wdata  = mem_q + 1'b1;
    mem_raddr  = flat;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_IDLE:   mem_raddr = HIST_AW'(read_bin);
      S_SQ_M: begin
        mul_a = 33'(diff);
        mul_b = 33'(diff);
      end
      S_LEN_GO: begin
        sqrt_start = 1'b1;
        sqrt_rad   = SQRT_IW'(sq_sel);
      end
      S_V_NUM: begin
        mul_a = $signed({8'b0, lp});
        mul_b = $signed({8'b0, lr});
      end
      S_V_SH: begin
        if (den < DEN_W'(64'h1_0000_0000)) begin
          div_start = 1'b1;
          div_dvd   = DIV_NW'({mag[31:0], 30'b0});
          div_dvs   = den[DIV_DW-1:0];
        end
      end
      S_V_SIN: begin
        mul_a = $signed({2'b00, cm});
        mul_b = $signed({2'b00, cm});
      end
      S_V_SQ: begin
        sqrt_start = 1'b1;
        sqrt_rad   = SQRT_IW'(64'h1000_0000_0000_0000) - SQRT_IW'(mul_p[60:0]);
      end
      S_O_ANG: begin
        if (ang_ok && scl_ok) begin
          div_start = 1'b1;
          div_dvd   = DIV_NW'({len_t, 12'b0});
          div_dvs   = DIV_DW'(len_b);
        end
      end
      S_O_RATW: begin
        if (div_done && rat_ok) begin
          div_start = 1'b1;
          div_dvd   = DIV_NW'(rdiff) * DIV_NW'(RATIO_BINS);
          div_dvs   = DIV_DW'(ratio_high - ratio_low);
        end
      end
      S_O_RBW: begin
        if (div_done) begin
          div_start = 1'b1;
          div_dvd   = DIV_NW'(len_s - scale_low) * DIV_NW'(SCALE_BINS);
          div_dvs   = DIV_DW'(scale_high - scale_low);
        end
      end
      S_O_WR:   mem_we = 1'b1;
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
      side_i   <= '0;
      axis_i   <= '0;
      sort_i   <= '0;
      len_i    <= '0;
      oidx     <= '0;
      vidx     <= 1'b0;
      ci       <= '0;
      added    <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == HIST_AW'(HIST_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            if (cmd == CMD_READ) begin
              rd_ok <= 32'(read_bin) < 32'(HIST_DEPTH);
              state <= S_RD;
            end else begin
              pax <= ax; pay <= ay; paz <= az;
              pbx <= bx; pby <= by_coord; pbz <= bz;
              pcx <= cx; pcy <= cy; pcz <= cz;
              side_i <= '0;
              axis_i <= '0;
              added  <= '0;
              state  <= S_SQ_M;
            end
          end
        end
        S_RD: begin
          done       <= 1'b1;
          bin_count  <= rd_ok ? mem_q : '0;
          bins_added <= '0;
          state      <= S_IDLE;
        end
        S_SQ_M: state <= S_SQ_A;
        S_SQ_A: begin
          acc <= acc_next;
          state <= S_SQ_M;
          if (axis_i == 2'd2) begin
            axis_i <= '0;
            case (side_i)
              2'd0:    sq0 <= acc_next;
              2'd1:    sq1 <= acc_next;
              default: sq2 <= acc_next;
            endcase
            if (side_i == 2'd2) begin
              sort_i <= '0;
              state  <= S_SORT;
            end else begin
              side_i <= side_i + 1'b1;
            end
          end else begin
            axis_i <= axis_i + 1'b1;
          end
        end
        S_SORT: begin
          sort_i <= sort_i + 1'b1;
          if (sort_i == 2'd0 && (sq0 == '0 || sq1 == '0 || sq2 == '0)) begin
            state <= S_DONE;
          end else begin
            case (sort_i)
              2'd1:    if (sq1 > sq2) begin sq1 <= sq2; sq2 <= sq1; end
              default: if (sq0 > sq1) begin sq0 <= sq1; sq1 <= sq0; end
            endcase
            if (sort_i == 2'd2) begin
              len_i <= '0;
              state <= S_LEN_GO;
            end
          end
        end
        S_LEN_GO: state <= S_LEN_W;
        S_LEN_W: begin
          if (sqrt_done) begin
            case (len_i)
              2'd0:    len0 <= sqrt_root[LEN_W-1:0];
              2'd1:    len1 <= sqrt_root[LEN_W-1:0];
              default: len2 <= sqrt_root[LEN_W-1:0];
            endcase
            if (len_i == 2'd2) begin
              vidx  <= 1'b0;
              state <= S_V_NUM;
            end else begin
              len_i <= len_i + 1'b1;
              state <= S_LEN_GO;
            end
          end
        end
        S_V_NUM: begin
          num   <= num_calc;
          state <= S_V_DEN;
        end
        S_V_DEN: begin
          den   <= {mul_p[DEN_W-2:0], 1'b0};
          mag   <= num[NUM_W-1] ? DEN_W'(-num) : DEN_W'(num);
          state <= S_V_CMP;
        end
        S_V_CMP: begin
          if (mag >= den) begin
            cm    <= COS_W'(COS_ONE);
            state <= S_V_SIN;
          end else begin
            state <= S_V_SH;
          end
        end
        S_V_SH: begin
          if (den < DEN_W'(64'h1_0000_0000)) begin
            state <= S_V_DIV;
          end else begin
            den <= den >> 1;
            mag <= mag >> 1;
          end
        end
        S_V_DIV: begin
          if (div_done) begin
            cm    <= div_q[COS_W-1:0];
            state <= S_V_SIN;
          end
        end
        S_V_SIN: state <= S_V_SQ;
        S_V_SQ:  state <= S_V_SQW;
        S_V_SQW: begin
          if (sqrt_done) begin
            ci <= '0;
            if (num[NUM_W-1] && cm != '0) begin
              cx_r <= XY_W'(sqrt_root);
              cy_r <= $signed(XY_W'(cm));
              cz_r <= $signed(Z_W'(ANG_HALF));
            end else begin
              cx_r <= $signed(XY_W'(cm));
              cy_r <= XY_W'(sqrt_root);
              cz_r <= '0;
            end
            state <= S_V_COR;
          end
        end
        S_V_COR: begin
          if (cy_r > 0) begin
            cx_r <= cx_r + cdy;
            cy_r <= cy_r - cdx;
            cz_r <= cz_r + ct;
          end else begin
            cx_r <= cx_r - cdy;
            cy_r <= cy_r + cdx;
            cz_r <= cz_r - ct;
          end
          ci <= ci + 1'b1;
          if (ci == 5'(CORDIC_STEPS - 1)) state <= S_V_END;
        end
        S_V_END: begin
          if (vidx) begin
            if (cz_r < 0) ang1 <= '0;
            else if (cz_r > $signed(Z_W'(ANG_ONE))) ang1 <= ANG_W'(ANG_ONE);
            else ang1 <= cz_r[ANG_W-1:0];
            oidx  <= '0;
            state <= S_O_ANG;
          end else begin
            if (cz_r < 0) ang0 <= '0;
            else if (cz_r > $signed(Z_W'(ANG_ONE))) ang0 <= ANG_W'(ANG_ONE);
            else ang0 <= cz_r[ANG_W-1:0];
            vidx  <= 1'b1;
            state <= S_V_NUM;
          end
        end
        S_O_ANG: begin
          ab <= BIN_W'(ang_scaled >> 20);
          if (ang_ok && scl_ok) state <= S_O_RATW;
          else state <= S_O_NEXT;
        end
        S_O_RATW: begin
          if (div_done) state <= rat_ok ? S_O_RBW : S_O_NEXT;
        end
        S_O_RBW: begin
          if (div_done) begin
            rb    <= div_q[BIN_W-1:0];
            state <= S_O_SBW;
          end
        end
        S_O_SBW: begin
          if (div_done) begin
            flat  <= HIST_AW'(32'(div_q[BIN_W-1:0]) * 32'(RATIO_BINS * ANGLE_BINS)
                              + 32'(rb) * 32'(ANGLE_BINS) + 32'(ab));
            state <= S_O_RD;
          end
        end
        S_O_RD: state <= S_O_WR;
        S_O_WR: begin
          added <= added + 1'b1;
          state <= S_O_NEXT;
        end
        S_O_NEXT: begin
          if (oidx == 2'd2) begin
            state <= S_DONE;
          end else begin
            oidx  <= oidx + 1'b1;
            state <= S_O_ANG;
          end
        end
        S_DONE: begin
          done       <= 1'b1;
          bin_count  <= '0;
          bins_added <= added;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/tsh_div.sv =====
// ----------------------------------------------------------------------------
// tsh_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsh_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tsh_pkg::DIV_NW-1:0] dividend,
  input  logic [tsh_pkg::DIV_DW-1:0] divisor,
  output logic                       done,
  output logic [tsh_pkg::DIV_NW-1:0] quotient
);
  import tsh_pkg::*;

  localparam int CW = $clog2(DIV_NW);

  logic              active;
  logic [CW-1:0]     cnt;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dvs;
  logic [DIV_NW-1:0] dvd;
  logic [DIV_DW:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem, dvd[DIV_NW-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start && !active) begin
        active   <= 1'b1;
        cnt      <= CW'(DIV_NW - 1);
        rem      <= '0;
        dvs      <= divisor;
        dvd      <= dividend;
        quotient <= '0;
      end else if (active) begin
        dvd <= dvd << 1;
        if (fits) begin
          rem      <= DIV_DW'(rem_sh - {1'b0, dvs});
          quotient <= {quotient[DIV_NW-2:0], 1'b1};
        end else begin
          rem      <= rem_sh[DIV_DW-1:0];
          quotient <= {quotient[DIV_NW-2:0], 1'b0};
        end
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/tsh_sqrt.sv =====
// ----------------------------------------------------------------------------
// tsh_sqrt
// Floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module tsh_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tsh_pkg::SQRT_IW-1:0] radicand,
  output logic                        done,
  output logic [tsh_pkg::SQRT_OW-1:0] root
);
  import tsh_pkg::*;

  localparam int CW = $clog2(SQRT_OW);
  localparam int RW = SQRT_OW + 4;

  logic               active;
  logic [CW-1:0]      cnt;
  logic [RW-1:0]      rem;
  logic [SQRT_IW-1:0] rad;
  logic [RW-1:0]      rem_sh;
  logic [RW-1:0]      trial;
  logic               fits;

  assign rem_sh = {rem[RW-3:0], rad[SQRT_IW-1 -: 2]};
  assign trial  = RW'({root, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start && !active) begin
        active <= 1'b1;
        cnt    <= CW'(SQRT_OW - 1);
        rem    <= '0;
        rad    <= radicand;
        root   <= '0;
      end else if (active) begin
        rad <= rad << 2;
        if (fits) begin
          rem  <= rem_sh - trial;
          root <= {root[SQRT_OW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[SQRT_OW-2:0], 1'b0};
        end
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule
